FILE: rtl/core/kalman_nlms_echo_canceller_macros.svh
// Assertion macros for the echo canceller
`ifndef KALMAN_NLMS_ECHO_CANCELLER_MACROS_SVH
`define KALMAN_NLMS_ECHO_CANCELLER_MACROS_SVH
`ifndef SYNTHESIS
`define KNEC_ASSERT_IMPL(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");
`define KNEC_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");
`else
`define KNEC_ASSERT_IMPL(label, clk, rst, ante, cons)
`define KNEC_ASSERT_NEXT(label, clk, rst, ante, cons)
`endif
`endif

FILE: rtl/core/knec_pkg.sv
// Shared types, constants and helpers of the echo canceller
package knec_pkg;
   localparam int TAPS  = 16;
   localparam int IDX_W = $clog2(TAPS);

   localparam logic [31:0] VAR_INIT  = 32'd10737;
   localparam logic [31:0] EPS8      = 32'd11;
   localparam logic [31:0] ALPHA_Q30 = 32'd107374182;
   localparam logic [31:0] BETA_Q30  = 32'd966367642;
   localparam logic [31:0] ONE_Q30   = 32'd1073741824;
   localparam logic [63:0] DELTA_MAX = 64'h2000_0000_0000_0000;
   localparam logic [63:0] QUOT_MAX  = 64'h0000_0000_8000_0000;

   // saturate a signed 64-bit value to int32
   function automatic logic [31:0] sat_s32(input logic signed [63:0] v);
      logic [31:0] r;
      if (v > 64'sd2147483647) r = 32'h7FFF_FFFF;
      else if (v < -64'sd2147483648) r = 32'h8000_0000;
      else r = v[31:0];
      return r;
   endfunction

   // saturate an unsigned 64-bit value to 32 bits
   function automatic logic [31:0] sat_u32(input logic [63:0] v);
      logic [31:0] r;
      r = (v[63:32] != 32'd0) ? 32'hFFFF_FFFF : v[31:0];
      return r;
   endfunction

   // divider request and status
   typedef struct packed {
      logic        start;
      logic [63:0] num;
      logic [63:0] den;
      logic [5:0]  shift;
      logic [63:0] limit;
   } div_req_type;

   typedef struct packed {
      logic        done;
      logic [63:0] quot;
   } div_rsp_type;
endpackage

FILE: rtl/core/knec_div.sv
// Restoring divider: floor(num * 2^shift / den), saturating at limit
module knec_div (
   input  logic                 clock,
   input  logic                 reset,
   input  knec_pkg::div_req_type req,
   output knec_pkg::div_rsp_type rsp
);
   import knec_pkg::*;

   logic [63:0]  den_ff, den_in, lim_ff, lim_in;
   logic [127:0] rem_ff, rem_in;
   logic [63:0]  q_ff, q_in;
   logic [6:0]   cnt_ff, cnt_in;
   logic [5:0]   shf_ff, shf_in;
   logic         busy_ff, busy_in, done_ff, done_in, sat_ff, sat_in;
   logic [127:0] trial;
   logic [63:0]  qn;
   logic [64:0]  qs;

   // one quotient bit per cycle: 64 integer bits, then shift fraction bits
   always_comb begin
      den_in = den_ff; lim_in = lim_ff; rem_in = rem_ff; q_in = q_ff;
      cnt_in = cnt_ff; shf_in = shf_ff; busy_in = busy_ff; done_in = 1'b0;
      sat_in = sat_ff;
      trial = {rem_ff[126:0], 1'b0};
      qn = q_ff; qs = 65'd0;
      if (req.start) begin
         den_in = (req.den == 64'd0) ? 64'd1 : req.den;
         lim_in = req.limit; rem_in = {64'd0, req.num}; q_in = 64'd0;
         cnt_in = 7'd0; shf_in = req.shift; busy_in = 1'b1; sat_in = 1'b0;
      end else if (busy_ff) begin
         if (cnt_ff < 7'd64) begin
            // integer phase: shift numerator bits in from low half
            trial = {rem_ff[126:64], rem_ff[63], rem_ff[62:0], 1'b0};
            qn = {q_ff[62:0], 1'b0};
            if (trial[127:64] >= den_ff) begin
               trial[127:64] = trial[127:64] - den_ff; qn[0] = 1'b1;
            end
            rem_in = trial; q_in = qn;
            if (cnt_ff == 7'd63 && qn > lim_ff) sat_in = 1'b1;
         end else begin
            // fraction phase
            qs = {q_ff, 1'b0};
            if (q_ff > {1'b0, lim_ff[63:1]}) sat_in = 1'b1;
            trial = {rem_ff[126:64], 1'b0, 64'd0};
            if (trial[127:64] >= den_ff) begin
               trial[127:64] = trial[127:64] - den_ff; qs[0] = 1'b1;
            end
            rem_in = trial; q_in = qs[63:0];
         end
         cnt_in = cnt_ff + 7'd1;
         if (cnt_ff == 7'd63 + {1'b0, shf_ff}) begin
            busy_in = 1'b0; done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      den_ff <= den_in; lim_ff <= lim_in; rem_ff <= rem_in; q_ff <= q_in;
      cnt_ff <= cnt_in; shf_ff <= shf_in;
      if (reset) begin
         busy_ff <= 1'b0; done_ff <= 1'b0; sat_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in; done_ff <= done_in; sat_ff <= sat_in;
      end
   end

   assign rsp.done = done_ff;
   assign rsp.quot = (sat_ff || q_ff > lim_ff) ? lim_ff : q_ff;
endmodule

FILE: rtl/core/knec_mem.sv
// Tap memory: delay line and coefficients, registered read data
module knec_mem (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       we,
   input  logic [knec_pkg::IDX_W-1:0] waddr,
   input  logic [63:0]                wdata,
   input  logic [knec_pkg::IDX_W-1:0] raddr,
   output logic [63:0]                rdata
);
   import knec_pkg::*;

   logic [63:0] mem [TAPS];
   logic [63:0] rd_ff;
   logic [TAPS-1:0] vld_ff;
   logic vsel_ff;

   // write entry {past, coef}; entries read as zero until written
   always_ff @(posedge clock) begin
      if (we) mem[waddr] <= wdata;
      rd_ff <= mem[raddr];
      if (reset) begin
         vld_ff <= '0; vsel_ff <= 1'b0;
      end else begin
         if (we) vld_ff[waddr] <= 1'b1;
         vsel_ff <= vld_ff[raddr];
      end
   end
   assign rdata = vsel_ff ? rd_ff : 64'd0;
endmodule

FILE: rtl/core/kalman_nlms_echo_canceller.sv
// Top level of the Kalman NLMS echo canceller
// Throughput: one word at a time; a new word can be taken as soon as the result is posted;
// the tap memory passes and the shared bit-serial divider set it.
// Reset: synchronous, clears delay line, coefficients and variances to their initial values.
`include "kalman_nlms_echo_canceller_macros.svh"
module kalman_nlms_echo_canceller (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   input  logic signed [15:0] req_mic_sample,
   input  logic               req_adapt,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output logic signed [15:0] rsp_out_sample
);
   import knec_pkg::*;
   localparam int AW = IDX_W;
   localparam logic [AW-1:0] LAST = AW'(TAPS - 1);

   typedef enum logic [14:0] {
      S_IDLE  = 15'h0001, S_DIN   = 15'h0002,
      S_DOT   = 15'h0004, S_ERR   = 15'h0008,
      S_DELTA = 15'h0010, S_DWT   = 15'h0020,
      S_UDIV  = 15'h0040, S_UWT   = 15'h0080,
      S_RHO   = 15'h0100, S_RWT   = 15'h0200,
      S_SQR   = 15'h0400, S_PWR   = 15'h0800,
      S_NV    = 15'h1000, S_SHIFT = 15'h2000,
      S_OUT   = 15'h4000
   } state_type;

   state_type st_ff, st_in;
   logic [AW-1:0] idx_ff, idx_in;
   logic          ph_ff, ph_in;
   logic signed [31:0] d_ff, d_in, y_ff, y_in, e_ff, e_in;
   logic signed [63:0] acc_ff, acc_in;
   logic [63:0] en_ff, en_in, den_ff, den_in, sq_ff, sq_in, rm_ff, rm_in;
   logic [31:0] pv_ff, pv_in, sv_ff, sv_in, sp_ff, sp_in, ep_ff, ep_in;
   logic [31:0] nv_ff, nv_in, carry_ff, carry_in;
   logic [31:0] dsq_ff, dsq_in, ysq_ff, ysq_in;
   logic signed [63:0] prod_ff, prod_in;
   logic        adapt_ff, adapt_in, ovl_ff, ovl_in;
   logic signed [15:0] o_ff, o_in;
   logic        ov_ff, ov_in;
   logic [63:0] dmag_ff, dmag_in;

   logic          we;
   logic [AW-1:0] waddr, raddr;
   logic [63:0]   wdata, rdata;
   div_req_type   dreq;
   div_rsp_type   drsp;

   knec_mem u_mem (
      .clock(clock), .reset(reset), .we(we), .waddr(waddr), .wdata(wdata),
      .raddr(raddr), .rdata(rdata));
   knec_div u_div (.clock(clock), .reset(reset), .req(dreq), .rsp(drsp));

   logic signed [31:0] px, cx;
   logic signed [63:0] pe, ucoef;
   logic [63:0] pmag, mag, t64;
   logic signed [31:0] u;
   logic [15:0] dsum;
   logic [31:0] dq;
   assign px = rdata[63:32];
   assign cx = rdata[31:0];

   // sequence read-modify-write passes over the tap memory
   always_comb begin
      st_in = st_ff; idx_in = idx_ff; ph_in = ph_ff;
      d_in = d_ff; y_in = y_ff; e_in = e_ff; acc_in = acc_ff;
      en_in = en_ff; den_in = den_ff; sq_in = sq_ff; rm_in = rm_ff;
      pv_in = pv_ff; sv_in = sv_ff; sp_in = sp_ff; ep_in = ep_ff; nv_in = nv_ff;
      dsq_in = dsq_ff; ysq_in = ysq_ff;
      carry_in = carry_ff; prod_in = prod_ff; adapt_in = adapt_ff;
      ovl_in = ovl_ff; o_in = o_ff; ov_in = ov_ff; dmag_in = dmag_ff;
      we = 1'b0; waddr = idx_ff; wdata = rdata; raddr = idx_ff;
      dreq = '0; pe = '0; pmag = '0; u = '0; ucoef = '0; mag = '0; t64 = '0;
      dsum = '0; dq = '0;
      // drop the result word once taken
      if (ov_ff && !rsp_stall) ov_in = 1'b0;
      unique case (st_ff)
         S_IDLE: begin
            if (req_valid) begin
               adapt_in = req_adapt;
               dmag_in = {48'd0, (req_mic_sample < 0) ? 16'(-req_mic_sample)
                                                     : 16'(req_mic_sample)};
               ovl_in = req_mic_sample < 0;
               idx_in = '0; ph_in = 1'b0; acc_in = '0; en_in = '0;
               st_in = S_DIN;
            end
         end
         S_DIN: begin
            // m * 2^28 / 32767 = m * 2^13 + m * 2^13 / 32767, since 2^15 = 1 mod 32767
            dsum = {2'b00, dmag_ff[15:2]} + {1'b0, dmag_ff[1:0], 13'd0};
            dq = {3'd0, dmag_ff[15:0], 13'd0} + {18'd0, dmag_ff[15:2]} +
                 {31'd0, (dsum >= 16'd32767)};
            d_in = ovl_ff ? -dq : dq;
            st_in = S_DOT;
         end
         S_DOT: begin
            // read issued at idx, consumed next cycle
            if (ph_ff) begin
               pe = 64'(px) * 64'(cx);
               acc_in = acc_ff + pe / 64'sd16384;
               t64 = 64'(px) * 64'(px);
               en_in = en_ff + (t64 >> 26);
               if (idx_ff == LAST) begin
                  st_in = S_ERR;
               end else idx_in = idx_ff + 1'b1;
               ph_in = 1'b0;
            end else ph_in = 1'b1;
         end
         S_ERR: begin
            y_in = sat_s32(acc_ff / 64'sd16384);
            e_in = sat_s32(64'(d_ff) - 64'(y_in));
            idx_in = '0; ph_in = 1'b0; sq_in = '0;
            if (adapt_ff) begin
               rm_in = {32'd0, sat_u32(64'(pv_ff) + 64'(sv_ff))};
               if (rm_in == 64'd0) rm_in = 64'd1;
               st_in = S_DELTA;
            end else st_in = S_SHIFT;
         end
         S_DELTA: begin
            dreq.start = 1'b1; dreq.num = {32'd0, nv_ff}; dreq.den = rm_ff;
            dreq.shift = 6'd30; dreq.limit = DELTA_MAX;
            st_in = S_DWT;
         end
         S_DWT: begin
            if (drsp.done) begin
               den_in = en_ff + drsp.quot;
               if (den_in == 64'd0) den_in = 64'd1;
               st_in = S_UDIV;
            end
         end
         S_UDIV: begin
            if (ph_ff) begin
               pe = 64'(px) * 64'(e_ff);
               prod_in = pe;
               pmag = pe[63] ? 64'(-pe) : 64'(pe);
               dreq.start = 1'b1; dreq.num = pmag; dreq.den = den_ff;
               dreq.shift = 6'd2; dreq.limit = QUOT_MAX;
               st_in = S_UWT; ph_in = 1'b0;
            end else ph_in = 1'b1;
         end
         S_UWT: begin
            raddr = idx_ff;
            if (drsp.done) begin
               u = prod_ff[63] ? sat_s32(-64'(drsp.quot)) : sat_s32(64'(drsp.quot));
               ucoef = 64'(cx) + 64'(u);
               we = 1'b1; wdata = {px, sat_s32(ucoef)};
               t64 = 64'(u) * 64'(u);
               sq_in = sq_ff + (t64 >> 26);
               if (idx_ff == LAST) st_in = S_RHO;
               else begin
                  idx_in = idx_ff + 1'b1; st_in = S_UDIV;
               end
            end
         end
         S_RHO: begin
            sv_in = sat_u32(sq_ff / 64'(TAPS) + 64'(EPS8));
            dreq.start = 1'b1; dreq.num = en_ff; dreq.den = den_ff;
            dreq.shift = 6'd30; dreq.limit = {32'd0, ONE_Q30};
            st_in = S_RWT;
         end
         S_RWT: begin
            if (drsp.done) begin
               t64 = 64'(ONE_Q30) - drsp.quot / 64'(TAPS);
               pv_in = sat_u32((64'(rm_ff[31:0]) * 64'(t64[31:0])) >> 30);
               st_in = S_SQR;
            end
         end
         S_SQR: begin
            // square sample and estimate
            dsq_in = sat_u32(64'(64'(d_ff) * 64'(d_ff)) >> 26);
            ysq_in = sat_u32(64'(64'(y_ff) * 64'(y_ff)) >> 26);
            st_in = S_PWR;
         end
         S_PWR: begin
            sp_in = sat_u32(((64'(ALPHA_Q30) * 64'(sp_ff)) >> 30) +
                            ((64'(BETA_Q30) * 64'(dsq_ff)) >> 30));
            ep_in = sat_u32(((64'(ALPHA_Q30) * 64'(ep_ff)) >> 30) +
                            ((64'(BETA_Q30) * 64'(ysq_ff)) >> 30));
            st_in = S_NV;
         end
         S_NV: begin
            nv_in = sat_u32(((sp_ff >= ep_ff) ? 64'(sp_ff - ep_ff)
                                             : 64'(ep_ff - sp_ff)) + 64'(EPS8));
            idx_in = '0; ph_in = 1'b0;
            st_in = S_SHIFT;
         end
         S_SHIFT: begin
            // push e into delay line, moving each past value one place down
            if (ph_ff) begin
               we = 1'b1; wdata = {(idx_ff == '0) ? e_ff : carry_ff, cx};
               carry_in = px;
               if (idx_ff == LAST) st_in = S_OUT;
               else idx_in = idx_ff + 1'b1;
               ph_in = 1'b0;
            end else ph_in = 1'b1;
         end
         S_OUT: begin
            // hold until the output register is free
            if (!ov_ff || !rsp_stall) begin
               mag = e_ff[31] ? 64'(-64'(e_ff)) : 64'(e_ff);
               if (mag >= 64'h1000_0000) o_in = 16'sd32767;
               else o_in = 16'((mag * 64'd32767) >> 28);
               if (e_ff[31]) o_in = -o_in;
               ov_in = 1'b1; st_in = S_IDLE;
            end
         end
         default: st_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      idx_ff <= idx_in; ph_ff <= ph_in; d_ff <= d_in; y_ff <= y_in; e_ff <= e_in;
      acc_ff <= acc_in; en_ff <= en_in; den_ff <= den_in; sq_ff <= sq_in;
      rm_ff <= rm_in; carry_ff <= carry_in; prod_ff <= prod_in;
      dsq_ff <= dsq_in; ysq_ff <= ysq_in;
      adapt_ff <= adapt_in; ovl_ff <= ovl_in; o_ff <= o_in; dmag_ff <= dmag_in;
      if (reset) begin
         st_ff <= S_IDLE; ov_ff <= 1'b0;
         pv_ff <= VAR_INIT; sv_ff <= VAR_INIT; nv_ff <= VAR_INIT;
         sp_ff <= '0; ep_ff <= '0;
      end else begin
         st_ff <= st_in; ov_ff <= ov_in;
         pv_ff <= pv_in; sv_ff <= sv_in; nv_ff <= nv_in; sp_ff <= sp_in; ep_ff <= ep_in;
      end
   end

   assign req_stall = (st_ff != S_IDLE);
   assign rsp_valid = ov_ff;
   assign rsp_out_sample = o_ff;

   `KNEC_ASSERT_IMPL(a_accept_idle, clock, reset, req_valid && !req_stall, st_ff == S_IDLE)
   `KNEC_ASSERT_NEXT(a_out_to_valid, clock, reset, st_ff == S_OUT, rsp_valid)
   `KNEC_ASSERT_IMPL(a_out_clamp, clock, reset, rsp_valid, rsp_out_sample != -16'sd32768)
   `KNEC_ASSERT_NEXT(a_out_hold, clock, reset, rsp_valid && rsp_stall, rsp_valid && $stable(rsp_out_sample))
endmodule
